### sv/bgpt_pkg.sv
package bgpt_pkg;
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;
    localparam logic CFG_NUM_ENTRIES = 1'b0;
    localparam logic CFG_DEFAULT_BPM = 1'b1;
    typedef struct packed {
        logic [31:0] time_ms;
        logic [15:0] tempo;
        logic [1:0]  phase;
    } t_entry;
    typedef struct packed {
        logic        start;
        logic [41:0] num;
        logic [31:0] den;
    } t_div_req;
    typedef struct packed {
        logic        done;
        logic [41:0] quo;
        logic [31:0] rem;
    } t_div_rsp;
endpackage

### sv/bgpt_div.sv
module bgpt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bgpt_pkg::t_div_req i_req,
    output bgpt_pkg::t_div_rsp o_rsp
);
    import bgpt_pkg::*;
    logic [41:0] r_quo;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [32:0] w_sh;
    logic [32:0] w_sub;

    assign w_sh  = {r_rem[31:0], r_quo[41]};
    assign w_sub = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd42;
                r_quo  <= i_req.num;
                r_rem  <= '0;
                r_den  <= i_req.den;
            end else if (r_busy) begin
                if (!w_sub[32]) begin
                    r_rem <= w_sub;
                    r_quo <= {r_quo[40:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[40:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[31:0];
endmodule

### sv/beat_grid_phase_tracker.sv
// Beat grid phase tracker.
// Input stream (s_axis): each transfer is either a table load or a position
// query, selected by tuser. A load writes one beat grid entry into a
// 4096-entry table, gives no result and leaves the block ready on the next
// cycle. With a loaded table, a query first reads entry 0; if the position
// lies after it, it binary-searches the table for the last beat at or before
// the position (up to 12 probes, each through S_PROBE, S_CMP and S_LEN on the
// single table read port), then runs up to two divisions on one shared
// restoring divider of 42 steps. With an empty table the fixed-tempo grid
// needs three divisions, or none when that tempo is zero or too high. The
// block takes one item at a time: s_axis_tready is high only while idle, and
// it rises again in the cycle after the result transfer. The result is held
// in registers until the m_axis transfer completes, so a stalled receiver
// simply keeps the block waiting with its input not ready. The entry count
// and the default tempo are written through the plain write port; the user
// must write them only while idle, as the block itself does not enforce this.
// Reset clears control state and both registers; the table holds no defined
// contents until loaded.
module beat_grid_phase_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // play_pos[31:0], entry_index[43:32], entry_time_ms[75:44],
    // entry_tempo_x100[91:76], entry_phase[93:92], zeros above
    input  logic [103:0] s_axis_tdata,
    // req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // state_valid[0], bar_beat[2:1], is_downbeat[3], beat_progress[13:4],
    // zeros above
    output logic [15:0] m_axis_tdata
);
    import bgpt_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0, S_PROBE = 4'd1, S_CMP = 4'd2,
        S_RD0 = 4'd3, S_RD1 = 4'd4, S_NEXT = 4'd5, S_LEN = 4'd6, S_DIVW = 4'd7,
        S_PERM = 4'd8, S_PERMW = 4'd9, S_OUT = 4'd10, S_EMPTY = 4'd11,
        S_EDIV = 4'd12, S_EDIVW = 4'd13, S_FIRST = 4'd14, S_HIT = 4'd15;

    // What the running division is for.
    localparam logic [1:0] DIV_NONE = 2'd0, DIV_LEN = 2'd1, DIV_PROG = 2'd2;

    t_entry r_mem [TABLE_DEPTH];
    t_entry r_rd;
    logic [IDX_W-1:0] r_addr;

    logic [3:0]  r_state;
    logic [CNT_W-1:0] r_count;
    logic [15:0] r_fb;
    logic [31:0] r_pos;
    logic [IDX_W-1:0] r_lo, r_hi, r_idx;
    logic [31:0] r_start, r_len, r_elapsed;
    logic [1:0]  r_phase, r_divsel;
    logic        r_valid;
    logic [9:0]  r_prog;
    logic        r_dstart;
    logic        n_dstart;
    logic [41:0] r_dnum;
    logic [31:0] r_dden;
    t_div_req    w_dreq;
    t_div_rsp    w_drsp;
    logic [CNT_W-1:0] w_cnt;
    logic [IDX_W-1:0] w_mid;
    logic [IDX_W:0]   w_sum;

    assign w_dreq = '{r_dstart, r_dnum, r_dden};

    bgpt_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    assign w_cnt = (r_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : r_count;
    assign w_sum = {1'b0, r_lo} + {1'b0, r_hi} + 13'd1;
    assign w_mid = w_sum[IDX_W:1];

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready && s_axis_tuser == REQ_LOAD)
            r_mem[s_axis_tdata[43:32]] <= {s_axis_tdata[75:44], s_axis_tdata[91:76],
                                            s_axis_tdata[93:92]};
        r_rd <= r_mem[r_addr];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    // The result registers stay still while the block waits in S_OUT.
    assign m_axis_tdata  = {2'b0, r_prog, (r_valid && r_phase == 2'd0), r_phase, r_valid};

    // The divider start pulse is raised in the cycle after a launching state.
    always_comb begin
        n_dstart = 1'b0;
        unique case (r_state)
            S_RD1:   n_dstart = (r_rd.tempo != 16'd0) || (r_fb != 16'd0);
            S_PERM:  n_dstart = (r_len != '0) && (r_elapsed < r_len);
            S_EMPTY: n_dstart = (r_fb != 16'd0) && (r_fb <= 16'd60000);
            S_EDIV:  n_dstart = w_drsp.done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_fb     <= '0;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= n_dstart;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_NUM_ENTRIES: r_count <= i_cfg_wdata[CNT_W-1:0];
                    CFG_DEFAULT_BPM: r_fb <= i_cfg_wdata;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tuser == REQ_QUERY) begin
                        r_pos <= s_axis_tdata[31:0];
                        r_lo  <= '0;
                        r_hi  <= IDX_W'(w_cnt - 13'd1);
                        r_addr <= '0;
                        r_state <= (w_cnt == '0) ? S_EMPTY : S_FIRST;
                    end
                end
                S_FIRST: r_state <= S_RD0;
                S_RD0: begin
                    r_idx <= '0;
                    r_state <= (r_pos > r_rd.time_ms) ? S_PROBE : S_RD1;
                end
                S_PROBE: begin
                    if (r_lo < r_hi) begin
                        r_addr <= w_mid;
                        r_state <= S_CMP;
                    end else begin
                        // Search done; read the chosen entry.
                        r_idx <= r_lo;
                        r_addr <= r_lo;
                        r_state <= S_HIT;
                    end
                end
                S_CMP: r_state <= S_LEN;
                S_LEN: begin
                    if (r_rd.time_ms <= r_pos) r_lo <= r_addr;
                    else r_hi <= r_addr - 12'd1;
                    r_state <= S_PROBE;
                end
                S_HIT: r_state <= S_RD1;
                S_RD1: begin
                    r_start <= r_rd.time_ms;
                    r_phase <= r_rd.phase;
                    r_elapsed <= (r_pos > r_rd.time_ms) ? r_pos - r_rd.time_ms : 32'd0;
                    r_len <= '0;
                    if (r_rd.tempo != 16'd0) begin
                        r_dnum <= 42'd6000000;
                        r_dden <= {16'd0, r_rd.tempo};
                        r_divsel <= DIV_LEN;
                    end else if (r_fb != 16'd0) begin
                        r_dnum <= 42'd60000;
                        r_dden <= {16'd0, r_fb};
                        r_divsel <= DIV_LEN;
                    end else begin
                        r_divsel <= DIV_NONE;
                    end
                    r_addr <= r_idx + 12'd1;
                    r_state <= S_NEXT;
                end
                S_NEXT: r_state <= S_DIVW;
                S_DIVW: begin
                    if (r_divsel == DIV_NONE || w_drsp.done) begin
                        // A later next entry sets the length; otherwise the tempo does, if there is one.
                        if ({1'b0, r_idx} + 13'd1 < w_cnt && r_rd.time_ms > r_start)
                            r_len <= r_rd.time_ms - r_start;
                        else if (r_divsel != DIV_NONE)
                            r_len <= w_drsp.quo[31:0];
                        r_state <= S_PERM;
                    end
                end
                S_PERM: begin
                    if (r_len == '0) begin
                        r_prog <= '0;
                        r_state <= S_PERMW;
                        r_valid <= 1'b1;
                    end else if (r_elapsed >= r_len) begin
                        r_prog <= 10'd1000;
                        r_valid <= 1'b1;
                        r_state <= S_PERMW;
                    end else begin
                        r_dnum <= 42'(r_elapsed) * 42'd1000;
                        r_dden <= r_len;
                        r_divsel <= DIV_PROG;
                        r_state <= S_PERMW;
                        r_valid <= 1'b1;
                    end
                end
                S_PERMW: begin
                    if (r_divsel != DIV_PROG || w_drsp.done) begin
                        if (r_divsel == DIV_PROG) r_prog <= w_drsp.quo[9:0];
                        r_divsel <= DIV_NONE;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready && m_axis_tvalid) r_state <= S_IDLE;
                end
                S_EMPTY: begin
                    r_valid <= 1'b0;
                    r_phase <= '0;
                    r_prog  <= '0;
                    if (r_fb == 16'd0 || r_fb > 16'd60000) begin
                        r_state <= S_OUT;
                    end else begin
                        r_dnum <= 42'd60000;
                        r_dden <= {16'd0, r_fb};
                        r_state <= S_EDIV;
                    end
                end
                S_EDIV: if (w_drsp.done) begin
                    r_len <= w_drsp.quo[31:0];
                    r_dnum <= {10'd0, r_pos};
                    r_dden <= w_drsp.quo[31:0];
                    r_state <= S_EDIVW;
                end
                S_EDIVW: if (w_drsp.done) begin
                    r_phase <= w_drsp.quo[1:0];
                    r_elapsed <= w_drsp.rem;
                    r_state <= S_PERM;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
